/* sv/gbba_pkg.sv */
// Shared constants and helpers for the geographic bounding box accumulator.
`timescale 1ns / 1ps

package gbba_pkg;

  // Default angle resolution: pi is 2^(ANGLE_BITS-1) units.
  localparam int unsigned ANGLE_BITS_DEF = 16;

  // Width of the pad-free field packing rounded up to whole bytes.
  function automatic int unsigned byte_round(input int unsigned bits);
    return ((bits + 7) / 8) * 8;
  endfunction

endpackage

/* sv/geo_bounding_box_accumulator.sv */
// Top level of the geographic bounding box accumulator with antimeridian wrap.
// An input transfer passes through the input register and then the result register to the master side.
// One point per cycle when not stalled; the box state is updated as an item moves
// from the input register into the result register, so the next point sees it.
// Both registers advance while the result register is empty or being taken.
// Reset (rst, synchronous) empties the box, zeroes its edges and drops both valids.
`timescale 1ns / 1ps

module geo_bounding_box_accumulator
  import gbba_pkg::*;
#(
  parameter int unsigned ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          s_axis_tvalid,
  output logic                                          s_axis_tready,
  // lon, lat
  input  logic [byte_round(2 * ANGLE_BITS + 1)-1:0]     s_axis_tdata,
  // restart
  input  logic                                          s_axis_tuser,
  output logic                                          m_axis_tvalid,
  input  logic                                          m_axis_tready,
  // box_west, box_east, box_south, box_north
  output logic [byte_round(4 * ANGLE_BITS + 2)-1:0]     m_axis_tdata,
  // crosses
  output logic                                          m_axis_tuser
);

  localparam int unsigned LW = ANGLE_BITS + 1;
  localparam int unsigned AW = ANGLE_BITS;
  localparam int unsigned DW = ANGLE_BITS + 3;
  localparam int unsigned IW = byte_round(2 * ANGLE_BITS + 1);
  localparam int unsigned OW = byte_round(4 * ANGLE_BITS + 2);
  localparam int unsigned OPAD = OW - (2 * LW + 2 * AW);

  localparam logic signed [LW-1:0] LON_PI  = {2'b01, {(ANGLE_BITS - 1){1'b0}}};
  localparam logic signed [LW-1:0] LON_NPI = {2'b11, {(ANGLE_BITS - 1){1'b0}}};
  localparam logic signed [AW-1:0] LAT_HPI  = {2'b01, {(ANGLE_BITS - 2){1'b0}}};
  localparam logic signed [AW-1:0] LAT_NHPI = {2'b11, {(ANGLE_BITS - 2){1'b0}}};
  localparam logic signed [DW-1:0] TWO_PI  = {3'b001, {ANGLE_BITS{1'b0}}};

  // Grows the longitude span [w, e] to take in lon; d is the extension used.
  function automatic void grow_lon(
    input  logic signed [LW-1:0] w,
    input  logic signed [LW-1:0] e,
    input  logic signed [LW-1:0] lon,
    output logic signed [LW-1:0] wo,
    output logic signed [LW-1:0] eo,
    output logic signed [DW-1:0] d
  );
    logic signed [DW-1:0] wx;
    logic signed [DW-1:0] ex;
    logic signed [DW-1:0] lx;
    logic signed [DW-1:0] dw;
    logic signed [DW-1:0] de;
    logic                 covered;
    logic                 same_sign;
    wx = {{2{w[LW-1]}}, w};
    ex = {{2{e[LW-1]}}, e};
    lx = {{2{lon[LW-1]}}, lon};
    covered = 1'b0;
    dw = '0;
    de = '0;
    if (w <= e) begin
      if (lon > e) begin
        dw = wx - lx + TWO_PI;
        de = lx - ex;
      end else if (lon < w) begin
        dw = wx - lx;
        de = lx - ex + TWO_PI;
      end else begin
        covered = 1'b1;
      end
    end else begin
      if (lon <= e || w <= lon) begin
        covered = 1'b1;
      end else begin
        dw = wx - lx;
        de = lx - ex;
      end
    end
    same_sign = (e > 0 && lon > 0) || (e < 0 && lon < 0);
    wo = w;
    eo = e;
    d  = '0;
    if (!covered) begin
      if (dw < de || (dw == de && same_sign)) begin
        wo = lon;
        d  = dw;
      end else begin
        eo = lon;
        d  = de;
      end
    end
  endfunction

  // Input register.
  logic                 in_valid;
  logic                 in_restart;
  logic signed [LW-1:0] in_lon;
  logic signed [AW-1:0] in_lat;

  // Box state.
  logic signed [LW-1:0] west_edge;
  logic signed [LW-1:0] east_edge;
  logic signed [AW-1:0] south_edge;
  logic signed [AW-1:0] north_edge;
  logic                 box_valid;

  // Result register.
  logic                 out_valid;
  logic                 out_crosses;

  logic                 advance;
  logic signed [LW-1:0] lon_c;
  logic signed [LW-1:0] lon_neg;
  logic signed [AW-1:0] lat_c;
  logic signed [LW-1:0] w1, e1, w2, e2;
  logic signed [DW-1:0] d1, d2;
  logic signed [LW-1:0] west_next;
  logic signed [LW-1:0] east_next;
  logic signed [AW-1:0] south_next;
  logic signed [AW-1:0] north_next;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_comb begin
    if (in_lon > LON_PI) begin
      lon_c = LON_PI;
    end else if (in_lon < LON_NPI) begin
      lon_c = LON_NPI;
    end else begin
      lon_c = in_lon;
    end
    if (in_lat > LAT_HPI) begin
      lat_c = LAT_HPI;
    end else if (in_lat < LAT_NHPI) begin
      lat_c = LAT_NHPI;
    end else begin
      lat_c = in_lat;
    end
    lon_neg = -lon_c;

    grow_lon(west_edge, east_edge, lon_c, w1, e1, d1);
    grow_lon(west_edge, east_edge, lon_neg, w2, e2, d2);

    if (in_restart || !box_valid) begin
      west_next  = lon_c;
      east_next  = lon_c;
      south_next = lat_c;
      north_next = lat_c;
    end else begin
      south_next = (lat_c < south_edge) ? lat_c : south_edge;
      north_next = (lat_c > north_edge) ? lat_c : north_edge;
      // On the antimeridian both signs are tried; the shorter growth wins, and on a
      // tie the first one is kept only if its west edge lies strictly below its east edge.
      if ((lon_c == LON_PI || lon_c == LON_NPI) && !(d1 < d2 || (d1 == d2 && w1 < e1))) begin
        west_next = w2;
        east_next = e2;
      end else begin
        west_next = w1;
        east_next = e1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      out_valid  <= 1'b0;
      box_valid  <= 1'b0;
      west_edge  <= '0;
      east_edge  <= '0;
      south_edge <= '0;
      north_edge <= '0;
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid  <= 1'b1;
        box_valid  <= 1'b1;
        west_edge  <= west_next;
        east_edge  <= east_next;
        south_edge <= south_next;
        north_edge <= north_next;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_restart <= s_axis_tuser;
      in_lon     <= s_axis_tdata[LW-1:0];
      in_lat     <= s_axis_tdata[LW+AW-1:LW];
    end
    if (advance) begin
      out_crosses <= west_next > east_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_crosses;
  assign m_axis_tdata  = {{OPAD{1'b0}}, north_edge, south_edge, east_edge, west_edge};

  logic unused_in_pad;
  assign unused_in_pad = ^s_axis_tdata[IW-1:LW+AW] ^ (IW == 0);

endmodule

/* sv/gbba_checker.sv */
// Port-level checks for the geographic bounding box accumulator, bound to the top level.
`timescale 1ns / 1ps

module gbba_checker
  import gbba_pkg::*;
#(
  parameter int unsigned ANGLE_BITS = ANGLE_BITS_DEF
) (
  input logic                                      clk,
  input logic                                      rst,
  input logic                                      s_axis_tvalid,
  input logic                                      s_axis_tready,
  input logic [byte_round(2 * ANGLE_BITS + 1)-1:0] s_axis_tdata,
  input logic                                      s_axis_tuser,
  input logic                                      m_axis_tvalid,
  input logic                                      m_axis_tready,
  input logic [byte_round(4 * ANGLE_BITS + 2)-1:0] m_axis_tdata,
  input logic                                      m_axis_tuser
);

  localparam int unsigned LW = ANGLE_BITS + 1;
  localparam int unsigned AW = ANGLE_BITS;
  localparam logic signed [AW-1:0] LAT_HPI  = {2'b01, {(ANGLE_BITS - 2){1'b0}}};
  localparam logic signed [AW-1:0] LAT_NHPI = {2'b11, {(ANGLE_BITS - 2){1'b0}}};

  logic signed [LW-1:0] west;
  logic signed [LW-1:0] east;
  logic signed [AW-1:0] south;
  logic signed [AW-1:0] north;

  assign west  = m_axis_tdata[LW-1:0];
  assign east  = m_axis_tdata[2*LW-1:LW];
  assign south = m_axis_tdata[2*LW+AW-1:2*LW];
  assign north = m_axis_tdata[2*LW+2*AW-1:2*LW+AW];

  logic unused_in;
  assign unused_in = s_axis_tvalid ^ s_axis_tready ^ s_axis_tuser ^ (^s_axis_tdata);

  // A stalled result keeps its content.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // The wrap flag agrees with the edges it travels with.
  a_cross: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tuser == (west > east))
    else $error("crosses flag disagrees with west and east edges");

  // Latitude edges stay ordered and within the poles.
  a_lat: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> south <= north && south >= LAT_NHPI && north <= LAT_HPI)
    else $error("latitude edges out of order or out of range");

  // An untaken result is not dropped before it is transferred.
  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    $past(m_axis_tvalid) && !$past(m_axis_tready) && !$past(rst) |-> m_axis_tvalid)
    else $error("result dropped before transfer");

endmodule

bind geo_bounding_box_accumulator gbba_checker #(.ANGLE_BITS(ANGLE_BITS)) u_gbba_checker (.*);
